// ===== src/mbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mbpc_pkg
// Shared widths, constants and register indexes of the multi-button press
// counter.
// ----------------------------------------------------------------------------
package mbpc_pkg;

  localparam int NUM_BUTTONS_DEF = 8;
  localparam int HW_BUTTONS      = 8;

  localparam int IDX_W    = 3;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 8;
  localparam int COUNT_W  = 4;
  localparam int ID_W     = 3;
  localparam int WIN_W    = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;
  localparam logic [SLOT_W-1:0]  SLOT_LIMIT = 4'd11;

  localparam logic [7:0]  ENABLE_RST = 8'h00;
  localparam logic [7:0]  INVERT_RST = 8'h00;
  localparam logic [23:0] IDS_RST    = 24'h000000;
  localparam logic [31:0] SLOTS_RST  = 32'hFFFF_FFFF;
  localparam logic [WIN_W-1:0] WINDOW_RST = 16'd5000;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd4;

endpackage

// ===== src/mbpc_if.sv =====
// ----------------------------------------------------------------------------
// mbpc_evt_if / mbpc_res_if
// Valid/ready channels for button events and status byte results.
// ----------------------------------------------------------------------------
interface mbpc_evt_if;
  import mbpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  button_index;
  logic              pin_level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, button_index, pin_level, now_ms, input ready);
  modport sink   (input valid, button_index, pin_level, now_ms, output ready);
endinterface

interface mbpc_res_if;
  import mbpc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot;
  logic [STATUS_W-1:0] status_byte;

  modport source (output valid, slot, status_byte, input ready);
  modport sink   (input valid, slot, status_byte, output ready);
endinterface

// ===== src/multi_button_press_counter_core.sv =====
// ----------------------------------------------------------------------------
// multi_button_press_counter_core
// Tracks press levels, press counts and press times per button and emits a
// packed status byte for each level change of an enabled button on a reportable slot.
// ----------------------------------------------------------------------------
// Flow: a release result is registered in S_CHECK. A press that restarts its run
// on its own press time goes through S_UPDATE; otherwise the other buttons' press
// times are scanned in S_SCAN, one button per cycle through one shared subtract
// and compare unit, before S_UPDATE. The next event is taken once the result beat
// has left, or with no beat when an event is ignored or its slot suppressed, so an
// output stall holds the input. Reset (synchronous, active high) clears all levels,
// counts and press times and loads the register reset values.
// ----------------------------------------------------------------------------
module multi_button_press_counter_core #(
  parameter int NUM_BUTTONS = mbpc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mbpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  mbpc_evt_if.sink                         evt,
  mbpc_res_if.source                       res
);
  import mbpc_pkg::*;

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [AW-1:0] LAST_J = AW'(NUM_BUTTONS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCAN, S_UPDATE, S_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [7:0]       enable_mask;
  logic [7:0]       invert_mask;
  logic [23:0]      button_ids;
  logic [31:0]      slot_indexes;
  logic [WIN_W-1:0] repeat_window;

  // Per-button state
  logic               pressed [NUM_BUTTONS];
  logic [COUNT_W-1:0] counts  [NUM_BUTTONS];
  logic [TIME_W-1:0]  times   [NUM_BUTTONS];

  // Captured event and working registers
  logic [IDX_W-1:0]  evt_idx;
  logic              evt_level;
  logic [TIME_W-1:0] evt_now;
  logic [TIME_W-1:0] mine;
  logic              restart;
  logic [AW-1:0]     j;

  logic                res_valid;
  logic [SLOT_W-1:0]   res_slot;
  logic [STATUS_W-1:0] res_status;

  logic [AW-1:0]       idx_a;
  logic [AW-1:0]       rd_addr;
  logic [TIME_W-1:0]   t_rd;
  logic [TIME_W-1:0]   diff;
  logic                gt_win;
  logic                lt_win;
  logic                idx_ok;
  logic                idx_en;
  logic                logical;
  logic                j_hit;
  logic [SLOT_W-1:0]   sel_slot;
  logic [ID_W-1:0]     sel_id;
  logic [COUNT_W-1:0]  cnt_new;

  function automatic logic en_bit(input logic [7:0] mask, input int k);
    en_bit = (k < HW_BUTTONS) ? mask[k[2:0]] : 1'b0;
  endfunction

  assign idx_a   = AW'(evt_idx);
  assign idx_ok  = (int'(evt_idx) < NUM_BUTTONS);
  assign idx_en  = idx_ok && enable_mask[evt_idx];
  assign logical = evt_level ^ invert_mask[evt_idx];

  // One read port on the time table, shared by the own-time check and the scan.
  assign rd_addr = (state == S_CHECK) ? idx_a : j;
  assign t_rd    = times[rd_addr];

  // Shared wrapping subtract and window compare.
  assign diff   = evt_now - t_rd;
  assign gt_win = diff > {{(TIME_W-WIN_W){1'b0}}, repeat_window};
  assign lt_win = diff < {{(TIME_W-WIN_W){1'b0}}, repeat_window};

  assign j_hit = (j != idx_a) && en_bit(enable_mask, int'(j)) &&
                 (t_rd != '0) && (t_rd > mine) && lt_win;

  assign sel_slot = slot_indexes[SLOT_W*evt_idx +: SLOT_W];
  assign sel_id   = button_ids[ID_W*evt_idx +: ID_W];
  assign cnt_new  = restart ? COUNT_W'(1) :
                    (counts[idx_a] < COUNT_MAX) ? counts[idx_a] + COUNT_W'(1) :
                    counts[idx_a];

  assign evt.ready       = (state == S_IDLE);
  assign res.valid       = res_valid;
  assign res.slot        = res_slot;
  assign res.status_byte = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      res_valid     <= 1'b0;
      restart       <= 1'b0;
      j             <= '0;
      enable_mask   <= ENABLE_RST;
      invert_mask   <= INVERT_RST;
      button_ids    <= IDS_RST;
      slot_indexes  <= SLOTS_RST;
      repeat_window <= WINDOW_RST;
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        pressed[k] <= 1'b0;
        counts[k]  <= '0;
        times[k]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE: enable_mask   <= cfg_data[7:0];
          REG_INVERT: invert_mask   <= cfg_data[7:0];
          REG_IDS:    button_ids    <= cfg_data[23:0];
          REG_SLOTS:  slot_indexes  <= cfg_data[31:0];
          REG_WINDOW: repeat_window <= cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (evt.valid) begin
            evt_idx   <= evt.button_index;
            evt_level <= evt.pin_level;
            evt_now   <= evt.now_ms;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!idx_en || (logical == pressed[idx_a])) begin
            state <= S_IDLE;
          end else if (!logical) begin
            // Release: only the level changes.
            pressed[idx_a] <= 1'b0;
            res_slot       <= sel_slot;
            res_status     <= {1'b0, counts[idx_a], sel_id};
            if (sel_slot < SLOT_LIMIT) begin
              res_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            mine    <= t_rd;
            restart <= (t_rd == '0) || gt_win;
            j       <= '0;
            if ((t_rd == '0) || gt_win) begin
              state <= S_UPDATE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // A later press of another button inside the window ends this run.
          if (j_hit) begin
            restart <= 1'b1;
            state   <= S_UPDATE;
          end else if (j == LAST_J) begin
            state <= S_UPDATE;
          end else begin
            j <= j + AW'(1);
          end
        end
        S_UPDATE: begin
          pressed[idx_a] <= 1'b1;
          times[idx_a]   <= evt_now;
          // A restart clears the other enabled counts; this button gets its new count.
          for (int k = 0; k < NUM_BUTTONS; k++) begin
            if (k == int'(idx_a)) begin
              counts[k] <= cnt_new;
            end else if (restart && en_bit(enable_mask, k)) begin
              counts[k] <= '0;
            end
          end
          res_slot      <= sel_slot;
          res_status    <= {1'b1, cnt_new, sel_id};
          if (sel_slot < SLOT_LIMIT) begin
            res_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (res.ready) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.slot < SLOT_LIMIT))
    else $error("result slot out of range");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && evt.ready) |=> !res.valid)
    else $error("result in the cycle after an event beat");

  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !evt.ready)
    else $error("event taken while a result waits");

  a_press_count: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status_byte[7]) |-> (res.status_byte[6:3] != '0))
    else $error("press reported with zero count");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-button press counter. A directed table of
// button events covers presses, releases, unchanged levels, suppressed slots,
// inverted pins, timestamp wrap and presses at time zero. Random phases then
// follow under several register settings, with press bursts and
// window-boundary timing. Every status beat is checked against the directed
// table's typed rows or a predictor that keeps its own levels, counts and press times.
// ----------------------------------------------------------------------------
module tb_top;
  import mbpc_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int SETTLE_CYCLES = HW_BUTTONS + 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;
  localparam int DIR_ROWS      = 24;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status_byte;
  } status_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]  button;
    logic              level;
    logic [TIME_W-1:0] stamp;
    logic              typed;
    logic              has_beat;
    status_beat_t      beat;
  } press_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mbpc_evt_if evt_ch ();
  mbpc_res_if res_ch ();

  multi_button_press_counter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_ch),
    .res       (res_ch)
  );

  // Predictor copy of the registers and per-button state.
  logic [7:0]        en_mask   = ENABLE_RST;
  logic [7:0]        inv_mask  = INVERT_RST;
  logic [23:0]       id_map    = IDS_RST;
  logic [31:0]       slot_map  = SLOTS_RST;
  logic [WIN_W-1:0]  window_ms = WINDOW_RST;
  logic              level_q      [HW_BUTTONS];
  logic [COUNT_W-1:0] count_q     [HW_BUTTONS];
  logic [TIME_W-1:0] press_time_q [HW_BUTTONS];

  status_beat_t pending_status [$];
  logic [TIME_W-1:0] clock_ms;

  bit          allow_idle;
  bit          quiet;
  int unsigned stall_left;
  int unsigned cycle_count = 0;
  int unsigned n_events;
  int unsigned n_expected;
  int unsigned n_checked = 0;
  int unsigned n_settings;
  int unsigned n_errors = 0;

  // Expected results of the directed table. Typed rows are the ones whose
  // beat is obvious; the rest go through the predictor.
  press_row_t dir_rows [DIR_ROWS] = '{
    '{3'd0, 1'b1, 32'd1000,       1'b1, 1'b1, '{4'd0, 8'h88}},
    '{3'd0, 1'b1, 32'd1010,       1'b1, 1'b0, '{4'd0, 8'h00}},
    '{3'd0, 1'b0, 32'd1020,       1'b1, 1'b1, '{4'd0, 8'h08}},
    '{3'd0, 1'b1, 32'd1050,       1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd1, 1'b1, 32'd1060,       1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd0, 1'b0, 32'd1070,       1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd0, 1'b1, 32'd1080,       1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd1, 1'b0, 32'd1090,       1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd1, 1'b1, 32'd1500,       1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd1, 1'b0, 32'd1510,       1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd5, 1'b1, 32'd1520,       1'b1, 1'b0, '{4'd0, 8'h00}},
    '{3'd5, 1'b0, 32'd1530,       1'b1, 1'b0, '{4'd0, 8'h00}},
    '{3'd7, 1'b0, 32'd1540,       1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd7, 1'b1, 32'd1550,       1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd2, 1'b1, 32'd0,          1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd2, 1'b0, 32'd10,         1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd2, 1'b1, 32'd50,         1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd4, 1'b1, 32'hFFFF_FFF0,  1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd4, 1'b0, 32'hFFFF_FFFF,  1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd4, 1'b1, 32'h0000_0010,  1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd3, 1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd3, 1'b0, 32'd1600,       1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd6, 1'b1, 32'h7FFF_FFFF,  1'b0, 1'b0, '{4'd0, 8'h00}},
    '{3'd6, 1'b0, 32'h8000_0000,  1'b0, 1'b0, '{4'd0, 8'h00}}
  };

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Returns 1 and the status beat when the event changes a button's level
  // and its slot is reportable. Updates the predictor state either way.
  function automatic bit predict_status(input logic [IDX_W-1:0] b, input logic lvl,
                                        input logic [TIME_W-1:0] stamp,
                                        output status_beat_t beat);
    logic              pressed;
    logic [TIME_W-1:0] mine;
    logic [TIME_W-1:0] win;
    logic [SLOT_W-1:0] s;
    bit                restart;
    beat = '0;
    if (!en_mask[b]) return 1'b0;
    pressed = lvl ^ inv_mask[b];
    if (pressed == level_q[b]) return 1'b0;
    level_q[b] = pressed;
    if (pressed) begin
      mine = press_time_q[b];
      win  = {{(TIME_W-WIN_W){1'b0}}, window_ms};
      if (count_q[b] != COUNT_MAX) count_q[b] = count_q[b] + 1'b1;
      restart = (mine == '0) || ((stamp - mine) > win);
      // A later press of another button inside the window breaks this run.
      if (mine != '0) begin
        for (int j = 0; j < HW_BUTTONS; j++) begin
          if (j != b && en_mask[j] && press_time_q[j] != '0 && press_time_q[j] > mine &&
              (stamp - press_time_q[j]) < win) begin
            restart = 1'b1;
          end
        end
      end
      if (restart) begin
        for (int j = 0; j < HW_BUTTONS; j++) begin
          if (en_mask[j]) count_q[j] = '0;
        end
        count_q[b] = 4'd1;
      end
      press_time_q[b] = stamp;
    end
    s = slot_map[4*b +: 4];
    if (s >= SLOT_LIMIT) return 1'b0;
    beat.slot        = s;
    beat.status_byte = {pressed, count_q[b], id_map[3*b +: 3]};
    return 1'b1;
  endfunction

  function automatic press_row_t event_row(input logic [IDX_W-1:0] b, input logic lvl,
                                           input logic [TIME_W-1:0] stamp);
    press_row_t row;
    row        = '0;
    row.button = b;
    row.level  = lvl;
    row.stamp  = stamp;
    return row;
  endfunction

  // Event that flips the stored level of button b.
  function automatic press_row_t toggle_row(input logic [IDX_W-1:0] b,
                                            input logic [TIME_W-1:0] stamp);
    return event_row(b, ~level_q[b] ^ inv_mask[b], stamp);
  endfunction

  function automatic logic [IDX_W-1:0] pick_button();
    logic [IDX_W-1:0] b;
    b = IDX_W'($urandom_range(0, HW_BUTTONS - 1));
    if (en_mask != '0) begin
      while (!en_mask[b]) b = IDX_W'($urandom_range(0, HW_BUTTONS - 1));
    end
    return b;
  endfunction

  // Moves the event clock on, favoring steps near the window edge.
  function automatic logic [TIME_W-1:0] advance_clock();
    int unsigned w;
    int unsigned sel;
    w   = window_ms;
    sel = $urandom_range(0, 9);
    if (sel <= 5) clock_ms = clock_ms + $urandom_range(0, w);
    else if (sel == 6) clock_ms = clock_ms + w;
    else if (sel == 7) clock_ms = clock_ms + w + 1;
    else clock_ms = clock_ms + $urandom_range(w + 2, 3 * w + 2);
    return clock_ms;
  endfunction

  function automatic logic [31:0] rand_slot_map();
    logic [31:0] m;
    for (int k = 0; k < HW_BUTTONS; k++) begin
      m[4*k +: 4] = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(11, 15)) :
                                                  4'($urandom_range(0, 10));
    end
    return m;
  endfunction

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Called only while the block is idle.
  task automatic apply_config(input logic [7:0] en, input logic [7:0] inv,
                              input logic [23:0] ids, input logic [31:0] slots,
                              input logic [WIN_W-1:0] win);
    reg_write(REG_ENABLE, {24'd0, en});
    reg_write(REG_INVERT, {24'd0, inv});
    reg_write(REG_IDS, {8'd0, ids});
    reg_write(REG_SLOTS, slots);
    reg_write(REG_WINDOW, {16'd0, win});
    cfg_we    <= 1'b0;
    en_mask   = en;
    inv_mask  = inv;
    id_map    = ids;
    slot_map  = slots;
    window_ms = win;
    n_settings++;
  endtask

  task automatic send_event(input press_row_t row);
    status_beat_t beat;
    bit           has;
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      evt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    evt_ch.valid        <= 1'b1;
    evt_ch.button_index <= row.button;
    evt_ch.pin_level    <= row.level;
    evt_ch.now_ms       <= row.stamp;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    has = predict_status(row.button, row.level, row.stamp, beat);
    if (row.typed) begin
      has  = row.has_beat;
      beat = row.beat;
    end
    if (has) begin
      pending_status.push_back(beat);
      n_expected++;
    end
    n_events++;
  endtask

  // Holds the sender until every expected beat is out and the block settles.
  task automatic wait_idle();
    evt_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input bit with_burst, input bit mid_drain);
    logic [IDX_W-1:0] b;
    int unsigned      kind;
    int unsigned      step;
    if (with_burst) begin
      // Rapid presses of one button, long enough to reach the count limit.
      b    = pick_button();
      step = window_ms / 16;
      for (int k = 0; k < 36; k++) begin
        clock_ms = clock_ms + $urandom_range(0, step);
        send_event(toggle_row(b, clock_ms));
      end
    end
    for (int i = 0; i < n_items; i++) begin
      if (i % 25 == 0) allow_idle = !quiet && ($urandom_range(0, 3) != 0);
      if (mid_drain && i == n_items / 2) wait_idle();
      kind = $urandom_range(0, 19);
      if (kind <= 13) begin
        send_event(toggle_row(pick_button(), advance_clock()));
      end else if (kind <= 16) begin
        send_event(event_row(IDX_W'($urandom_range(0, HW_BUTTONS - 1)),
                             1'($urandom_range(0, 1)), advance_clock()));
      end else if (kind == 17) begin
        clock_ms = $urandom;
        send_event(toggle_row(pick_button(), clock_ms));
      end else begin
        // Out-of-order timestamp.
        clock_ms = clock_ms - $urandom_range(0, window_ms);
        send_event(toggle_row(pick_button(), clock_ms));
      end
    end
  endtask

  // Result side: random stall bursts, and the check of each beat.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        n_checked++;
        if (pending_status.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("ERROR: unexpected beat slot=%0d status=%02h",
                     res_ch.slot, res_ch.status_byte);
        end else if (res_ch.slot !== pending_status[0].slot ||
                     res_ch.status_byte !== pending_status[0].status_byte) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("ERROR: beat %0d expected slot=%0d status=%02h, got slot=%0d status=%02h",
                     n_checked, pending_status[0].slot, pending_status[0].status_byte,
                     res_ch.slot, res_ch.status_byte);
        end
        if (pending_status.size() != 0) void'(pending_status.pop_front());
      end
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        res_ch.ready <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 5) == 0) begin
        stall_left   <= $urandom_range(0, 2);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: run timed out with %0d beats outstanding", pending_status.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < HW_BUTTONS; k++) begin
      level_q[k]      = 1'b0;
      count_q[k]      = '0;
      press_time_q[k] = '0;
    end
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_ENABLE;
    cfg_data            <= '0;
    evt_ch.valid        <= 1'b0;
    evt_ch.button_index <= '0;
    evt_ch.pin_level    <= 1'b0;
    evt_ch.now_ms       <= '0;
    allow_idle          = 1'b1;
    quiet               = 1'b0;
    n_events            = 0;
    n_expected          = 0;
    n_settings          = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With reset values every button is disabled, so this beat is dropped.
    send_event(event_row(3'd0, 1'b1, 32'd1000));
    wait_idle();

    // Button 7 inverted, id k for button k, button 5 on a suppressed slot.
    apply_config(8'hFF, 8'h80, 24'hFAC688, 32'hA9B4_3210, 16'd100);
    for (int i = 0; i < DIR_ROWS; i++) send_event(dir_rows[i]);
    wait_idle();

    clock_ms = $urandom;
    apply_config(8'hFF, 8'($urandom), 24'($urandom), rand_slot_map(),
                 16'($urandom_range(50, 2000)));
    run_phase(60, 1'b1, 1'b0);
    wait_idle();
    apply_config(8'hFF, 8'($urandom), 24'($urandom), rand_slot_map(), 16'd1);
    run_phase(50, 1'b1, 1'b1);
    wait_idle();
    apply_config(8'hFF, 8'hFF, 24'hFFFFFF, 32'h0000_0000, 16'hFFFF);
    run_phase(60, 1'b1, 1'b0);
    wait_idle();
    // State keeps moving while every slot is suppressed.
    apply_config(8'hFF, 8'($urandom), 24'($urandom), 32'hFFFF_FFFF,
                 16'($urandom_range(100, 3000)));
    run_phase(30, 1'b0, 1'b0);
    wait_idle();
    apply_config(8'h00, 8'h00, 24'h000000, rand_slot_map(), 16'd5000);
    run_phase(10, 1'b0, 1'b0);
    wait_idle();
    apply_config(8'($urandom_range(1, 255)), 8'($urandom), 24'($urandom), $urandom,
                 16'($urandom_range(1, 65535)));
    run_phase(60, 1'b1, 1'b0);
    wait_idle();
    quiet      = 1'b1;
    allow_idle = 1'b0;
    apply_config(8'hFF, 8'($urandom), 24'($urandom), rand_slot_map(),
                 16'($urandom_range(100, 5000)));
    run_phase(60, 1'b1, 1'b0);
    wait_idle();

    $display("Sent %0d button events over %0d register settings, %0d of them reportable.",
             n_events, n_settings, n_expected);
    $display("Checked %0d status beats, with press bursts, window edges and wrapped times.",
             n_checked);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d", n_errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== multi_button_press_counter_core.f =====
src/mbpc_pkg.sv
src/mbpc_if.sv
src/multi_button_press_counter_core.sv
tb/tb_top.sv
